>>> src/blpr_pkg.sv
// Shared types and constants for the button long-press and auto-repeat detector.
`default_nettype none

package blpr_pkg;

    localparam int TIMER_W   = 14;
    localparam int LEVELS_W  = 10;
    localparam int MS_W      = 8;
    localparam int BIDX_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 14;

    localparam logic [TIMER_W-1:0] FIRST_HOLD_RESET = 14'd1000;
    localparam logic [TIMER_W-1:0] REPEAT_RESET     = 14'd200;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_HOLD_MS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPORT_ENABLE = 2'd2;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    typedef struct packed {
        logic [TIMER_W-1:0] timer;
        logic               long_reported;
        logic               first_long_done;
    } t_entry;

    typedef struct packed {
        logic [TIMER_W-1:0] first_hold_ms;
        logic [TIMER_W-1:0] repeat_ms;
        logic               report_enable;
    } t_cfg;

    typedef struct packed {
        logic              valid;
        logic [BIDX_W-1:0] button_index;
        logic              is_long;
        logic              last;
    } t_report;

endpackage

`default_nettype wire

>>> src/blpr_state_ram.sv
// Per-button state memory with registered read and reset-cleared valid bits.
`default_nettype none

module blpr_state_ram #(
    parameter int DEPTH  = 10,
    parameter int ADDR_W = 4
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_wr_en,
    input  wire [ADDR_W-1:0]      i_wr_addr,
    input  blpr_pkg::t_entry      i_wr_data,
    input  wire [ADDR_W-1:0]      i_rd_addr,
    output blpr_pkg::t_entry      o_rd_data
);
    import blpr_pkg::*;

    t_entry             r_mem [DEPTH];
    logic [DEPTH-1:0]   r_valid;
    t_entry             r_rd_data;
    logic               r_rd_valid;

    // An entry never written since reset reads as all zeros.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= r_valid[i_rd_addr];
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

`default_nettype wire

>>> src/blpr_engine.sv
// Sequencer that sweeps the button state memory once per request.
`default_nettype none

module blpr_engine #(
    parameter int NUM_BUTTONS = 10,
    parameter int IDX_W       = 4
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_start,
    input  wire                              i_op,
    input  wire [blpr_pkg::LEVELS_W-1:0]     i_levels,
    input  wire [blpr_pkg::MS_W-1:0]         i_ms,
    input  blpr_pkg::t_cfg                   i_cfg,
    input  wire                              i_out_can_load,
    output logic                             o_idle,
    output blpr_pkg::t_report                o_push
);
    import blpr_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUTTONS - 1);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_FLUSH} t_state;

    t_state                 r_state;
    logic [IDX_W-1:0]       r_idx;
    logic                   r_op;
    logic [LEVELS_W-1:0]    r_levels;
    logic [MS_W-1:0]        r_ms;
    logic [NUM_BUTTONS-1:0] r_prev;
    logic                   r_pend_v;
    logic [IDX_W-1:0]       r_pend_idx;
    logic                   r_pend_long;

    logic [NUM_BUTTONS-1:0] w_now;
    t_entry                 w_rd;
    t_entry                 n_entry;
    logic                   w_hit;
    logic                   w_hit_long;
    logic                   w_stall;
    logic                   w_wr_en;
    logic [IDX_W-1:0]       w_rd_addr;
    logic                   w_now_b;
    logic                   w_prev_b;

    // Buttons beyond the levels field always read as released.
    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_now
        if (g < LEVELS_W) begin : g_in
            assign w_now[g] = r_levels[g];
        end else begin : g_out
            assign w_now[g] = 1'b1;
        end
    end

    assign w_now_b  = w_now[r_idx];
    assign w_prev_b = r_prev[r_idx];

    always_comb begin
        n_entry    = w_rd;
        w_hit      = 1'b0;
        w_hit_long = 1'b0;
        if (r_op == OP_TICK) begin
            if (w_rd.timer < {{(TIMER_W-MS_W){1'b0}}, r_ms}) begin
                n_entry.timer = '0;
            end else begin
                n_entry.timer = w_rd.timer - {{(TIMER_W-MS_W){1'b0}}, r_ms};
            end
        end else if (w_prev_b && !w_now_b) begin
            n_entry.timer           = i_cfg.first_hold_ms;
            n_entry.long_reported   = 1'b0;
            n_entry.first_long_done = 1'b0;
        end else if (i_cfg.report_enable && !w_now_b && (w_rd.timer == '0)) begin
            n_entry.timer           = w_rd.first_long_done ? i_cfg.repeat_ms
                                                           : i_cfg.first_hold_ms;
            n_entry.first_long_done = 1'b1;
            n_entry.long_reported   = 1'b1;
            w_hit                   = 1'b1;
            w_hit_long              = 1'b1;
        end else if (i_cfg.report_enable && !w_prev_b && w_now_b && !w_rd.long_reported) begin
            w_hit = 1'b1;
        end
    end

    // A new report moves the pending one out; hold if the output is still full.
    assign w_stall = (r_state == S_RUN) && w_hit && r_pend_v && !i_out_can_load;
    assign w_wr_en = (r_state == S_RUN) && !w_stall;

    always_comb begin
        if (r_state != S_RUN) begin
            w_rd_addr = '0;
        end else if (w_stall) begin
            w_rd_addr = r_idx;
        end else if (r_idx == LAST_IDX) begin
            w_rd_addr = '0;
        end else begin
            w_rd_addr = r_idx + 1'b1;
        end
    end

    blpr_state_ram #(
        .DEPTH (NUM_BUTTONS),
        .ADDR_W(IDX_W)
    ) u_ram (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(r_idx),
        .i_wr_data(n_entry),
        .i_rd_addr(w_rd_addr),
        .o_rd_data(w_rd)
    );

    always_comb begin
        o_push              = '0;
        o_push.button_index = BIDX_W'(r_pend_idx);
        o_push.is_long      = r_pend_long;
        if (r_state == S_RUN) begin
            o_push.valid = w_hit && r_pend_v && i_out_can_load;
        end else if (r_state == S_FLUSH) begin
            o_push.valid = r_pend_v && i_out_can_load;
            o_push.last  = 1'b1;
        end
    end

    assign o_idle = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_prev   <= '1;
            r_pend_v <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_op     <= i_op;
                        r_levels <= i_levels;
                        r_ms     <= i_ms;
                        r_idx    <= '0;
                        r_state  <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (!w_stall) begin
                        if (w_hit) begin
                            r_pend_v    <= 1'b1;
                            r_pend_idx  <= r_idx;
                            r_pend_long <= w_hit_long;
                        end
                        if (r_idx == LAST_IDX) begin
                            if (r_op == OP_SAMPLE) begin
                                r_prev <= w_now;
                            end
                            r_state <= S_FLUSH;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_FLUSH: begin
                    if (!r_pend_v) begin
                        r_state <= S_IDLE;
                    end else if (i_out_can_load) begin
                        r_pend_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> src/button_long_press_repeat_core.sv
// Top level of the button long-press and auto-repeat detector.
// Each request is accepted, the state memory is swept button by button in a read-modify-write
// pass, and a flush state sends the last report. The sweep stalls whenever a report must leave
// while the output register is still full.
// Reset is synchronous and active low: the memory's valid bits clear at once so every button
// reads as idle with a zero timer, levels read as released, and registers take their defaults.
`default_nettype none

module button_long_press_repeat_core #(
    parameter int NUM_BUTTONS = 10
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // Configuration write port.
    input  wire                               i_cfg_wr_en,
    input  wire [blpr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [blpr_pkg::CFG_DAT_W-1:0]     i_cfg_wdata,
    // Request stream.
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire [23:0]                        s_tdata,   // levels[9:0], elapsed_ms[17:10], zeros
    input  wire                               s_tuser,   // operation
    // Report stream.
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [7:0]                        m_tdata,   // button_index[3:0], zeros
    output logic                              m_tuser,   // is_long
    output logic                              m_tlast    // last report of a request
);
    import blpr_pkg::*;

    localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    t_cfg              r_cfg;
    t_report           w_push;
    logic              w_idle;
    logic              w_out_can_load;
    logic              r_out_v;
    logic [BIDX_W-1:0] r_out_idx;
    logic              r_out_long;
    logic              r_out_last;

    // Configuration registers; writes to indexes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_hold_ms <= FIRST_HOLD_RESET;
            r_cfg.repeat_ms     <= REPEAT_RESET;
            r_cfg.report_enable <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_FIRST_HOLD_MS: r_cfg.first_hold_ms <= i_cfg_wdata[TIMER_W-1:0];
                REG_REPEAT_MS:     r_cfg.repeat_ms     <= i_cfg_wdata[TIMER_W-1:0];
                REG_REPORT_ENABLE: r_cfg.report_enable <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // The engine takes one request at a time; it is ready once its sweep and flush are finished,
    // even while the last report still waits in the output register.
    assign s_tready = w_idle;

    blpr_engine #(
        .NUM_BUTTONS(NUM_BUTTONS),
        .IDX_W      (IDX_W)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (s_tvalid && w_idle),
        .i_op          (s_tuser),
        .i_levels      (s_tdata[LEVELS_W-1:0]),
        .i_ms          (s_tdata[LEVELS_W+MS_W-1:LEVELS_W]),
        .i_cfg         (r_cfg),
        .i_out_can_load(w_out_can_load),
        .o_idle        (w_idle),
        .o_push        (w_push)
    );

    // Output register: loads when empty or when its current report is being taken.
    assign w_out_can_load = !r_out_v || m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_push.valid) begin
            r_out_v <= 1'b1;
        end else if (m_tready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push.valid) begin
            r_out_idx  <= w_push.button_index;
            r_out_long <= w_push.is_long;
            r_out_last <= w_push.last;
        end
    end

    assign m_tvalid = r_out_v;
    assign m_tdata  = {{(8-BIDX_W){1'b0}}, r_out_idx};
    assign m_tuser  = r_out_long;
    assign m_tlast  = r_out_last;

endmodule

`default_nettype wire
